// ===== hdl/ric_pkg.sv =====
// ----------------------------------------------------------------------------
// ric_pkg
// Types, codes and helpers shared by the reference-counted inode cache.
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CNT_MAX = 8'hFF;

  localparam logic [1:0] MODE_ACQUIRE   = 2'd0;
  localparam logic [1:0] MODE_DUPLICATE = 2'd1;
  localparam logic [1:0] MODE_RELEASE   = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  localparam logic [1:0] OP_ACQUIRE   = 2'd0;
  localparam logic [1:0] OP_DUPLICATE = 2'd1;
  localparam logic [1:0] OP_RELEASE   = 2'd2;
  localparam logic [1:0] OP_NOREF     = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_CLAIMED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOREF    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  device;
    logic [31:0] ino;
    logic [4:0]  slot;
  } req_t;

  typedef struct packed {
    logic [4:0] entry;
    logic [2:0] status;
    logic [7:0] ref_count;
    logic       last_reference;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device;
    logic [31:0] ino;
    logic [4:0]  slot;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [IDX_W-1:0] lowest_index(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/refcounted_inode_cache.sv =====
// ----------------------------------------------------------------------------
// refcounted_inode_cache
// Reference-counted table of inode tags: acquire by tag, duplicate, release.
// ----------------------------------------------------------------------------
// Sequence: a request waits in the queue, then passes the load, scan, pick and
// update steps of the execution sequencer before the result strobe rises; the
// next request is loaded only after that. A two-beat queue absorbs bursts.
// Reset: synchronous; all counts clear at once, tags stay undefined.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module refcounted_inode_cache (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ric_pkg::req_t req,
  output logic          done,
  output ric_pkg::rsp_t result
);

  ric_pkg::q_stat_t q_stat;
  ric_pkg::q_item_t push_item;
  ric_pkg::q_item_t pop_item;
  logic             push;
  logic             pop;

  ric_front u_front (
    .start  (start),
    .busy   (busy),
    .req    (req),
    .q_stat (q_stat),
    .push   (push),
    .item   (push_item)
  );

  ric_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .pop       (pop),
    .pop_data  (pop_item),
    .stat      (q_stat)
  );

  ric_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_data (pop_item),
    .q_stat (q_stat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done after reset");
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");
  a_last_ref: assert property (@(posedge clk) disable iff (rst)
    done && result.last_reference |-> result.ref_count == 8'd0 &&
    result.status == ric_pkg::ST_HIT)
    else $error("last reference with nonzero count");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push)
    else $error("push into full queue");
`endif

endmodule

// ===== hdl/ric_front.sv =====
// ----------------------------------------------------------------------------
// ric_front
// Request intake: takes a beat when the queue has room and classifies it.
// ----------------------------------------------------------------------------
module ric_front (
  input  logic             start,
  output logic             busy,
  input  ric_pkg::req_t    req,
  input  ric_pkg::q_stat_t q_stat,
  output logic             push,
  output ric_pkg::q_item_t item
);

  logic slot_out_of_range;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  assign slot_out_of_range = {4'b0, req.slot} >= 9'(ric_pkg::ENTRIES);

  always_comb begin
    item.device = req.device;
    item.ino    = req.ino;
    item.slot   = req.slot;
    unique case (req.mode)
      ric_pkg::MODE_ACQUIRE:   item.op = ric_pkg::OP_ACQUIRE;
      ric_pkg::MODE_DUPLICATE: item.op = slot_out_of_range ? ric_pkg::OP_NOREF
                                                           : ric_pkg::OP_DUPLICATE;
      ric_pkg::MODE_RELEASE:   item.op = slot_out_of_range ? ric_pkg::OP_NOREF
                                                           : ric_pkg::OP_RELEASE;
      default:                 item.op = ric_pkg::OP_NOREF;
    endcase
  end

endmodule

// ===== hdl/ric_queue.sv =====
// ----------------------------------------------------------------------------
// ric_queue
// Short queue between intake and execution.
// ----------------------------------------------------------------------------
module ric_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ric_pkg::q_item_t push_data,
  input  logic             pop,
  output ric_pkg::q_item_t pop_data,
  output ric_pkg::q_stat_t stat
);

  ric_pkg::q_item_t             mem [ric_pkg::QDEPTH];
  logic [ric_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ric_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ric_pkg::QCNT_W-1:0]   count;

  assign stat.full  = count == ric_pkg::QCNT_W'(ric_pkg::QDEPTH);
  assign stat.empty = count == '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ric_pkg::QPTR_W'(ric_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ric_pkg::QPTR_W'(ric_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/ric_back.sv =====
// ----------------------------------------------------------------------------
// ric_back
// Execution: holds tags and counts, scans, picks an entry, updates it.
// ----------------------------------------------------------------------------
module ric_back (
  input  logic             clk,
  input  logic             rst,
  input  ric_pkg::q_item_t q_data,
  input  ric_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             done,
  output ric_pkg::rsp_t    result
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state;
  logic [7:0]                refs     [ric_pkg::ENTRIES];
  logic [7:0]                tag_dev  [ric_pkg::ENTRIES];
  logic [31:0]               tag_ino  [ric_pkg::ENTRIES];
  ric_pkg::q_item_t          cur;
  logic [ric_pkg::ENTRIES-1:0] hit_vec;
  logic [ric_pkg::ENTRIES-1:0] free_vec;
  logic [ric_pkg::ENTRIES-1:0] hit_vec_next;
  logic [ric_pkg::ENTRIES-1:0] free_vec_next;
  logic [ric_pkg::IDX_W-1:0] pick_idx;
  logic [ric_pkg::IDX_W-1:0] pick_idx_next;
  logic [7:0]                pick_cnt;
  logic                      pick_hit;
  logic                      pick_free;
  logic                      ref_we;
  logic [7:0]                ref_wdata;
  logic                      claim;
  ric_pkg::rsp_t             result_next;

  assign pop = (state == S_LOAD) && !q_stat.empty;

  always_comb begin
    for (int i = 0; i < ric_pkg::ENTRIES; i++) begin
      free_vec_next[i] = refs[i] == 8'd0;
      hit_vec_next[i]  = (refs[i] != 8'd0) && (tag_dev[i] == cur.device) &&
                         (tag_ino[i] == cur.ino);
    end
  end

  always_comb begin
    if (cur.op == ric_pkg::OP_ACQUIRE) begin
      pick_idx_next = (|hit_vec) ? ric_pkg::lowest_index(hit_vec)
                                 : ric_pkg::lowest_index(free_vec);
    end else begin
      pick_idx_next = ric_pkg::IDX_W'(cur.slot);
    end
  end

  always_comb begin
    result_next.entry          = cur.slot;
    result_next.status         = ric_pkg::ST_NOREF;
    result_next.ref_count      = 8'd0;
    result_next.last_reference = 1'b0;
    ref_we    = 1'b0;
    ref_wdata = pick_cnt;
    claim     = 1'b0;
    unique case (cur.op)
      ric_pkg::OP_ACQUIRE: begin
        if (pick_hit) begin
          result_next.entry = 5'(pick_idx);
          if (pick_cnt == ric_pkg::CNT_MAX) begin
            result_next.status    = ric_pkg::ST_OVERFLOW;
            result_next.ref_count = ric_pkg::CNT_MAX;
          end else begin
            ref_we                = 1'b1;
            ref_wdata             = pick_cnt + 8'd1;
            result_next.status    = ric_pkg::ST_HIT;
            result_next.ref_count = pick_cnt + 8'd1;
          end
        end else if (pick_free) begin
          claim                 = 1'b1;
          ref_we                = 1'b1;
          ref_wdata             = 8'd1;
          result_next.entry     = 5'(pick_idx);
          result_next.status    = ric_pkg::ST_CLAIMED;
          result_next.ref_count = 8'd1;
        end else begin
          result_next.entry  = 5'd0;
          result_next.status = ric_pkg::ST_FULL;
        end
      end
      ric_pkg::OP_DUPLICATE: begin
        if (pick_cnt == ric_pkg::CNT_MAX) begin
          result_next.status    = ric_pkg::ST_OVERFLOW;
          result_next.ref_count = ric_pkg::CNT_MAX;
        end else if (pick_cnt != 8'd0) begin
          ref_we                = 1'b1;
          ref_wdata             = pick_cnt + 8'd1;
          result_next.status    = ric_pkg::ST_HIT;
          result_next.ref_count = pick_cnt + 8'd1;
        end
      end
      ric_pkg::OP_RELEASE: begin
        if (pick_cnt != 8'd0) begin
          ref_we                     = 1'b1;
          ref_wdata                  = pick_cnt - 8'd1;
          result_next.status         = ric_pkg::ST_HIT;
          result_next.ref_count      = pick_cnt - 8'd1;
          result_next.last_reference = pick_cnt == 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      done  <= 1'b0;
      for (int i = 0; i < ric_pkg::ENTRIES; i++) begin
        refs[i] <= 8'd0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (!q_stat.empty) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: state <= S_PICK;
        S_PICK: state <= S_DONE;
        S_DONE: begin
          done  <= 1'b1;
          state <= S_LOAD;
          if (ref_we) begin
            refs[pick_idx] <= ref_wdata;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (state == S_SCAN) begin
      hit_vec  <= hit_vec_next;
      free_vec <= free_vec_next;
    end
    if (state == S_PICK) begin
      pick_idx  <= pick_idx_next;
      pick_cnt  <= refs[pick_idx_next];
      pick_hit  <= |hit_vec;
      pick_free <= |free_vec;
    end
    if (state == S_DONE) begin
      result <= result_next;
      if (claim) begin
        tag_dev[pick_idx] <= cur.device;
        tag_ino[pick_idx] <= cur.ino;
      end
    end
  end

endmodule
